@@ rtl/core/bvp_pkg.sv @@
`timescale 1ns / 1ps

package bvp_pkg;

  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned CfgAddrWidth = 4;

  localparam logic [CfgAddrWidth-1:0] RegTimeStep = CfgAddrWidth'(0);

endpackage

@@ rtl/core/bvp_in_if.sv @@
`timescale 1ns / 1ps

interface bvp_in_if
  import bvp_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] vel_x;
  logic signed [DATA_WIDTH-1:0] vel_y;
  logic signed [DATA_WIDTH-1:0] vel_z;
  logic signed [DATA_WIDTH-1:0] efield_x;
  logic signed [DATA_WIDTH-1:0] efield_y;
  logic signed [DATA_WIDTH-1:0] efield_z;
  logic signed [DATA_WIDTH-1:0] bfield_x;
  logic signed [DATA_WIDTH-1:0] bfield_y;
  logic signed [DATA_WIDTH-1:0] bfield_z;

  modport source (
    output valid, vel_x, vel_y, vel_z, efield_x, efield_y, efield_z,
           bfield_x, bfield_y, bfield_z,
    input  ready
  );
  modport sink (
    input  valid, vel_x, vel_y, vel_z, efield_x, efield_y, efield_z,
           bfield_x, bfield_y, bfield_z,
    output ready
  );
endinterface

@@ rtl/core/bvp_out_if.sv @@
`timescale 1ns / 1ps

interface bvp_out_if
  import bvp_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] new_vel_x;
  logic signed [DATA_WIDTH-1:0] new_vel_y;
  logic signed [DATA_WIDTH-1:0] new_vel_z;
  logic                         overflow;

  modport source (
    output valid, new_vel_x, new_vel_y, new_vel_z, overflow,
    input  ready
  );
  modport sink (
    input  valid, new_vel_x, new_vel_y, new_vel_z, overflow,
    output ready
  );
endinterface

@@ rtl/core/boris_velocity_push.sv @@
`timescale 1ns / 1ps

// Boris velocity push, signed fixed point (default Q16.16). One item per clock
// when the output is taken every cycle. The factor 2/(1+|t|^2) comes from a
// restoring divider, which resolves one quotient bit per stage. A stall at the
// output holds the whole pipeline. time_step is written through the APB port at
// address 0 and must only change while no item is in flight; overflow flags any
// saturation.
module boris_velocity_push
  import bvp_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef,
  localparam int unsigned PW = (DATA_WIDTH > 32) ? 64 : 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [PW-1:0]           pwdata,
  output logic [PW-1:0]           prdata,
  output logic                    pready,
  bvp_in_if.sink                  in_i,
  bvp_out_if.source               out_o
);

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned QW   = 2 * F + 2;
  localparam int unsigned NDIV = QW;
  localparam int unsigned CW   = (QW + 1 > W) ? QW + 1 : W;
  localparam int unsigned SDV  = 5;
  localparam int unsigned SG   = SDV + NDIV;
  localparam int unsigned NS   = SG + 4;

  localparam logic [W-1:0]   MaxV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   MinV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]   OneQ = W'(1) << F;
  localparam logic [2*W:0]   RndC = (2*W+1)'(1) << (F - 1);
  localparam logic [2*W:0]   LimP = (2*W+1)'(MaxV);
  localparam logic [2*W:0]   LimN = (2*W+1)'(MaxV) + (2*W+1)'(1);

  typedef struct {
    logic signed [W-1:0] v   [3];
    logic signed [W-1:0] e   [3];
    logic signed [W-1:0] b   [3];
    logic signed [W-1:0] h   [3];
    logic signed [W-1:0] t   [3];
    logic signed [W-1:0] vm  [3];
    logic signed [W-1:0] vpr [3];
    logic signed [W-1:0] x   [6];
    logic [W-1:0]        d;
    logic [W:0]          rem;
    logic [QW-1:0]       quo;
    logic signed [W-1:0] k;
    logic                ovf;
  } stage_t;

  function automatic logic [W:0] qmul(input logic signed [W-1:0] a,
                                      input logic signed [W-1:0] b);
    logic signed [2*W-1:0] p;
    logic [2*W:0]          m;
    logic [2*W:0]          r;
    logic                  neg;
    logic                  sat;
    logic [W-1:0]          res;
    p   = a * b;
    neg = p[2*W-1];
    m   = neg ? -{p[2*W-1], p} : {1'b0, p};
    r   = (m + RndC) >> F;
    sat = neg ? (r > LimN) : (r > LimP);
    res = neg ? -r[W-1:0] : r[W-1:0];
    if (sat) begin
      res = neg ? MinV : MaxV;
    end
    return {sat, res};
  endfunction

  function automatic logic [W:0] sadd(input logic signed [W-1:0] a,
                                      input logic signed [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      return {1'b1, s[W] ? MinV : MaxV};
    end
    return {1'b0, s[W-1:0]};
  endfunction

  function automatic logic [W:0] ssub(input logic signed [W-1:0] a,
                                      input logic signed [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) begin
      return {1'b1, s[W] ? MinV : MaxV};
    end
    return {1'b0, s[W-1:0]};
  endfunction

  logic [W-1:0]        time_step_q;
  logic signed [W-1:0] half;
  logic                en;
  stage_t              pipe_q [NS];
  stage_t              pipe_d [NS];
  logic [NS-1:0]       vld_q;

  assign pready = 1'b1;
  assign prdata = PW'(time_step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= '0;
    end else if (psel && penable && pwrite && (paddr == RegTimeStep)) begin
      time_step_q <= pwdata[W-1:0];
    end
  end

  assign half = $signed(time_step_q) / 2;

  assign en         = !vld_q[NS-1] || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    logic [W:0]    r;
    logic [W:0]    a;
    logic [W:0]    n;
    logic [W:0]    dv;
    logic [QW:0]   q1;
    int            i;
    int            j;
    for (j = 1; j < NS; j++) begin
      pipe_d[j] = pipe_q[j-1];
    end
    pipe_d[0]      = pipe_q[0];
    pipe_d[0].v[0] = in_i.vel_x;
    pipe_d[0].v[1] = in_i.vel_y;
    pipe_d[0].v[2] = in_i.vel_z;
    pipe_d[0].e[0] = in_i.efield_x;
    pipe_d[0].e[1] = in_i.efield_y;
    pipe_d[0].e[2] = in_i.efield_z;
    pipe_d[0].b[0] = in_i.bfield_x;
    pipe_d[0].b[1] = in_i.bfield_y;
    pipe_d[0].b[2] = in_i.bfield_z;
    pipe_d[0].ovf  = 1'b0;

    // half kick and rotation vector
    for (i = 0; i < 3; i++) begin
      r = qmul(pipe_q[0].e[i], half);
      pipe_d[1].h[i] = r[W-1:0];
      a = qmul(pipe_q[0].b[i], half);
      pipe_d[1].t[i] = a[W-1:0];
      pipe_d[1].ovf  = pipe_d[1].ovf | r[W] | a[W];
    end

    for (i = 0; i < 3; i++) begin
      r = sadd(pipe_q[1].v[i], pipe_q[1].h[i]);
      pipe_d[2].vm[i] = r[W-1:0];
      a = qmul(pipe_q[1].t[i], pipe_q[1].t[i]);
      pipe_d[2].x[i] = a[W-1:0];
      pipe_d[2].ovf  = pipe_d[2].ovf | r[W] | a[W];
    end

    // norm, denominator, v- x t products
    r = sadd(pipe_q[2].x[0], pipe_q[2].x[1]);
    a = sadd(r[W-1:0], pipe_q[2].x[2]);
    n = sadd(OneQ, a[W-1:0]);
    pipe_d[3].d   = n[W-1:0];
    pipe_d[3].ovf = pipe_q[2].ovf | r[W] | a[W] | n[W];
    r = qmul(pipe_q[2].vm[1], pipe_q[2].t[2]); pipe_d[3].x[0] = r[W-1:0];
    pipe_d[3].ovf = pipe_d[3].ovf | r[W];
    r = qmul(pipe_q[2].vm[2], pipe_q[2].t[1]); pipe_d[3].x[1] = r[W-1:0];
    pipe_d[3].ovf = pipe_d[3].ovf | r[W];
    r = qmul(pipe_q[2].vm[2], pipe_q[2].t[0]); pipe_d[3].x[2] = r[W-1:0];
    pipe_d[3].ovf = pipe_d[3].ovf | r[W];
    r = qmul(pipe_q[2].vm[0], pipe_q[2].t[2]); pipe_d[3].x[3] = r[W-1:0];
    pipe_d[3].ovf = pipe_d[3].ovf | r[W];
    r = qmul(pipe_q[2].vm[0], pipe_q[2].t[1]); pipe_d[3].x[4] = r[W-1:0];
    pipe_d[3].ovf = pipe_d[3].ovf | r[W];
    r = qmul(pipe_q[2].vm[1], pipe_q[2].t[0]); pipe_d[3].x[5] = r[W-1:0];
    pipe_d[3].ovf = pipe_d[3].ovf | r[W];

    for (i = 0; i < 3; i++) begin
      r = ssub(pipe_q[3].x[2*i], pipe_q[3].x[2*i+1]);
      a = sadd(pipe_q[3].vm[i], r[W-1:0]);
      pipe_d[4].vpr[i] = a[W-1:0];
      pipe_d[4].ovf    = pipe_d[4].ovf | r[W] | a[W];
    end
    pipe_d[4].rem = '0;
    pipe_d[4].quo = '0;

    // one quotient bit per stage
    for (j = 0; j < NDIV; j++) begin
      dv = {1'b0, pipe_q[SDV+j-1].d};
      r  = {pipe_q[SDV+j-1].rem[W-1:0], (j == 0)};
      if (r >= dv) begin
        pipe_d[SDV+j].rem = r - dv;
        pipe_d[SDV+j].quo = {pipe_q[SDV+j-1].quo[QW-2:0], 1'b1};
      end else begin
        pipe_d[SDV+j].rem = r;
        pipe_d[SDV+j].quo = {pipe_q[SDV+j-1].quo[QW-2:0], 1'b0};
      end
    end

    dv = {1'b0, pipe_q[SG-1].d};
    q1 = {1'b0, pipe_q[SG-1].quo};
    if (pipe_q[SG-1].rem >= dv - pipe_q[SG-1].rem) begin
      q1 = q1 + (QW+1)'(1);
    end
    if (CW'(q1) > CW'(MaxV)) begin
      pipe_d[SG].k   = MaxV;
      pipe_d[SG].ovf = 1'b1;
    end else begin
      pipe_d[SG].k = W'(q1);
    end

    for (i = 0; i < 3; i++) begin
      r = qmul(pipe_q[SG].t[i], pipe_q[SG].k);
      pipe_d[SG+1].t[i] = r[W-1:0];
      pipe_d[SG+1].ovf  = pipe_d[SG+1].ovf | r[W];
    end

    // v' x s products
    r = qmul(pipe_q[SG+1].vpr[1], pipe_q[SG+1].t[2]); pipe_d[SG+2].x[0] = r[W-1:0];
    pipe_d[SG+2].ovf = pipe_d[SG+2].ovf | r[W];
    r = qmul(pipe_q[SG+1].vpr[2], pipe_q[SG+1].t[1]); pipe_d[SG+2].x[1] = r[W-1:0];
    pipe_d[SG+2].ovf = pipe_d[SG+2].ovf | r[W];
    r = qmul(pipe_q[SG+1].vpr[2], pipe_q[SG+1].t[0]); pipe_d[SG+2].x[2] = r[W-1:0];
    pipe_d[SG+2].ovf = pipe_d[SG+2].ovf | r[W];
    r = qmul(pipe_q[SG+1].vpr[0], pipe_q[SG+1].t[2]); pipe_d[SG+2].x[3] = r[W-1:0];
    pipe_d[SG+2].ovf = pipe_d[SG+2].ovf | r[W];
    r = qmul(pipe_q[SG+1].vpr[0], pipe_q[SG+1].t[1]); pipe_d[SG+2].x[4] = r[W-1:0];
    pipe_d[SG+2].ovf = pipe_d[SG+2].ovf | r[W];
    r = qmul(pipe_q[SG+1].vpr[1], pipe_q[SG+1].t[0]); pipe_d[SG+2].x[5] = r[W-1:0];
    pipe_d[SG+2].ovf = pipe_d[SG+2].ovf | r[W];

    // second half kick
    for (i = 0; i < 3; i++) begin
      r = ssub(pipe_q[SG+2].x[2*i], pipe_q[SG+2].x[2*i+1]);
      a = sadd(pipe_q[SG+2].vm[i], r[W-1:0]);
      n = sadd(a[W-1:0], pipe_q[SG+2].h[i]);
      pipe_d[SG+3].v[i] = n[W-1:0];
      pipe_d[SG+3].ovf  = pipe_d[SG+3].ovf | r[W] | a[W] | n[W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pipe_q <= pipe_d;
    end
  end

  assign out_o.valid     = vld_q[NS-1];
  assign out_o.new_vel_x = pipe_q[NS-1].v[0];
  assign out_o.new_vel_y = pipe_q[NS-1].v[1];
  assign out_o.new_vel_z = pipe_q[NS-1].v[2];
  assign out_o.overflow  = pipe_q[NS-1].ovf;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import bvp_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int LATENCY = 2 * FB + 11;
  localparam int N_RANDOM = 550;
  localparam longint MAXQ = 64'sd2147483647;
  localparam longint MINQ = -64'sd2147483648;
  localparam longint ONE_Q = 64'sd65536;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [DW-1:0] vx, vy, vz, ex, ey, ez, bx, by, bz;
  } particle_t;

  typedef struct packed {
    logic signed [DW-1:0] nx, ny, nz;
    logic                 ovf;
  } push_t;

  typedef struct {
    logic [DW-1:0] dt;
    particle_t     p;
    logic          has_exp;
    push_t         exp_push;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CfgAddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bvp_in_if  #(.DATA_WIDTH(DW)) in_ch ();
  bvp_out_if #(.DATA_WIDTH(DW)) out_ch ();

  boris_velocity_push #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) i_dut (
    .clk_i(clk), .rst_ni(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always #5 clk = ~clk;

  logic [DW-1:0] dt_q = '0;
  push_t velocity_fifo[$];
  int errors = 0;
  int pushes_seen = 0;
  int ovf_seen = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  bit hold_off = 1'b0;
  bit feed_done = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.vel_x, in_ch.vel_y, in_ch.vel_z} = '0;
    {in_ch.efield_x, in_ch.efield_y, in_ch.efield_z} = '0;
    {in_ch.bfield_x, in_ch.bfield_y, in_ch.bfield_z} = '0;
    out_ch.ready = 1'b0;
  end

  // fixed-point helpers; sat flags any clamp
  function automatic longint clamp(input longint x, inout bit sat);
    if (x > MAXQ) begin
      sat = 1'b1;
      return MAXQ;
    end
    if (x < MINQ) begin
      sat = 1'b1;
      return MINQ;
    end
    return x;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b, inout bit sat);
    logic signed [127:0] prod;
    logic [127:0] m;
    logic [127:0] r;
    bit neg;
    prod = 128'(a) * 128'(b);
    neg = prod < 0;
    m = neg ? 128'(-prod) : 128'(prod);
    r = (m + (128'(1) << (FB - 1))) >> FB;
    if (!neg && r > 128'(MAXQ)) begin
      sat = 1'b1;
      return MAXQ;
    end
    if (neg && r > 128'(MAXQ) + 1) begin
      sat = 1'b1;
      return MINQ;
    end
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3],
                                 output longint c[3], inout bit sat);
    c[0] = clamp(fx_mul(a[1], b[2], sat) - fx_mul(a[2], b[1], sat), sat);
    c[1] = clamp(fx_mul(a[2], b[0], sat) - fx_mul(a[0], b[2], sat), sat);
    c[2] = clamp(fx_mul(a[0], b[1], sat) - fx_mul(a[1], b[0], sat), sat);
  endfunction

  function automatic push_t boris_push(input logic [DW-1:0] dt, input particle_t p);
    longint half, n2, den, k, q;
    longint v[3], e[3], b[3], h[3], vm[3], t[3], s[3], vmt[3], vpr[3], vps[3];
    bit sat;
    push_t r;
    sat = 1'b0;
    half = longint'($signed(dt)) / 2;
    v = '{longint'(p.vx), longint'(p.vy), longint'(p.vz)};
    e = '{longint'(p.ex), longint'(p.ey), longint'(p.ez)};
    b = '{longint'(p.bx), longint'(p.by), longint'(p.bz)};
    for (int i = 0; i < 3; i++) begin
      h[i] = fx_mul(e[i], half, sat);
      vm[i] = clamp(v[i] + h[i], sat);
      t[i] = fx_mul(b[i], half, sat);
    end
    n2 = fx_mul(t[0], t[0], sat);
    n2 = clamp(n2 + fx_mul(t[1], t[1], sat), sat);
    n2 = clamp(n2 + fx_mul(t[2], t[2], sat), sat);
    den = clamp(ONE_Q + n2, sat);
    q = (longint'(1) << (2 * FB + 1)) / den;
    if (((longint'(1) << (2 * FB + 1)) % den) * 2 >= den) q++;
    k = clamp(q, sat);
    for (int i = 0; i < 3; i++) s[i] = fx_mul(t[i], k, sat);
    cross3(vm, t, vmt, sat);
    for (int i = 0; i < 3; i++) vpr[i] = clamp(vm[i] + vmt[i], sat);
    cross3(vpr, s, vps, sat);
    r.nx = DW'(clamp(clamp(vm[0] + vps[0], sat) + h[0], sat));
    r.ny = DW'(clamp(clamp(vm[1] + vps[1], sat) + h[1], sat));
    r.nz = DW'(clamp(clamp(vm[2] + vps[2], sat) + h[2], sat));
    r.ovf = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d (result %0d)", what, got, want,
             pushes_seen);
    errors++;
  endtask

  task automatic write_time_step(input logic [DW-1:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= RegTimeStep;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    dt_q = value;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (velocity_fifo.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_particle(input particle_t p, input bit do_idle);
    if (do_idle && idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.vel_x, in_ch.vel_y, in_ch.vel_z} <= {p.vx, p.vy, p.vz};
    {in_ch.efield_x, in_ch.efield_y, in_ch.efield_z} <= {p.ex, p.ey, p.ez};
    {in_ch.bfield_x, in_ch.bfield_y, in_ch.bfield_z} <= {p.bx, p.by, p.bz};
    do @(posedge clk); while (!in_ch.ready);
    velocity_fifo.push_back(boris_push(dt_q, p));
  endtask

  function automatic logic [DW-1:0] rand_q(input int mode);
    case (mode)
      0: return $urandom();
      1: return DW'($signed($urandom_range(0, 2 * 65536 * 4)) - 4 * 65536);
      2: return DW'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom_range(0, 1) ? DW'(MAXQ) : DW'(MINQ);
    endcase
  endfunction

  function automatic particle_t rand_particle(input bit wild);
    particle_t p;
    int m;
    m = wild ? 0 : 1;
    p.vx = rand_q(m); p.vy = rand_q(m); p.vz = rand_q(m);
    p.ex = rand_q(m); p.ey = rand_q(m); p.ez = rand_q(m);
    p.bx = rand_q(m); p.by = rand_q(m); p.bz = rand_q(m);
    if ($urandom_range(0, 15) == 0) p.bx = rand_q(3);
    if ($urandom_range(0, 15) == 0) p.vy = rand_q(3);
    return p;
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : sink_ready
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 6);
        repeat (n) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    push_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      pushes_seen++;
      if (velocity_fifo.size() == 0) begin
        $display("unexpected result %0d", pushes_seen);
        errors++;
      end else begin
        want = velocity_fifo.pop_front();
        if (out_ch.overflow) ovf_seen++;
        if (out_ch.new_vel_x !== want.nx) report_mismatch("new_vel_x", out_ch.new_vel_x, want.nx);
        if (out_ch.new_vel_y !== want.ny) report_mismatch("new_vel_y", out_ch.new_vel_y, want.ny);
        if (out_ch.new_vel_z !== want.nz) report_mismatch("new_vel_z", out_ch.new_vel_z, want.nz);
        if (out_ch.overflow !== want.ovf) report_mismatch("overflow", out_ch.overflow, want.ovf);
      end
    end
  end

  vector_t table_rows[$];

  task automatic add_row(input logic [DW-1:0] dt, input particle_t p, input bit has_exp,
                         input push_t e);
    vector_t r;
    r.dt = dt; r.p = p; r.has_exp = has_exp; r.exp_push = e;
    table_rows.push_back(r);
  endtask

  initial begin : stimulus
    particle_t p;
    push_t e;
    logic [DW-1:0] steps[6];
    steps = '{32'h0000_0000, 32'h0000_1000, 32'hFFFF_F000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h0000_0001};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero dt: velocity passes through unchanged
    p = '{32'sh0001_0000, -32'sh0002_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh8000_0000, 1, 32'sh7FFF_FFFF, 32'sh8000_0000, 0};
    e = '{32'sh0001_0000, -32'sh0002_0000, 32'sh7FFF_FFFF, 1'b0};
    add_row(steps[0], p, 1'b1, e);
    p = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 0, 0, 0};
    e = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0};
    add_row(steps[0], p, 1'b1, e);
    // dt=1: half truncates to zero
    p = '{5, -5, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    e = '{5, -5, 0, 1'b0};
    add_row(steps[5], p, 1'b1, e);
    for (int s = 1; s < 5; s++) begin
      add_row(steps[s], '{32'sh0001_0000, 0, 0, 0, 0, 0, 0, 0, 32'sh0001_0000}, 1'b0, e);
      add_row(steps[s], '{default: 32'sh7FFF_FFFF}, 1'b0, e);
      add_row(steps[s], '{default: 32'sh8000_0000}, 1'b0, e);
      add_row(steps[s], '{0, 32'sh0003_0000, 0, 32'sh0001_0000, 0, 0, 0, 0, -32'sh0002_0000},
              1'b0, e);
      add_row(steps[s], rand_particle(1'b0), 1'b0, e);
    end

    foreach (table_rows[i]) begin
      if (table_rows[i].dt !== dt_q || i == 0) begin
        drain();
        write_time_step(table_rows[i].dt);
      end
      if (table_rows[i].has_exp && boris_push(dt_q, table_rows[i].p) !== table_rows[i].exp_push) begin
        $display("predictor disagrees with table row %0d", i);
        errors++;
      end
      if (table_rows[i].has_exp) begin
        send_particle(table_rows[i].p, 1'b1);
        void'(velocity_fifo.pop_back());
        velocity_fifo.push_back(table_rows[i].exp_push);
      end else begin
        send_particle(table_rows[i].p, 1'b1);
      end
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 110 == 0) begin
        drain();
        case (i / 110)
          0: write_time_step(32'h0000_0800);
          1: write_time_step(32'h8000_0000);
          2: write_time_step($urandom());
          3: write_time_step(32'hFFFF_E000);
          default: write_time_step(32'h7FFF_FFFF);
        endcase
      end
      if (i == 150) hold_off = 1'b1;
      if (i == 300) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (velocity_fifo.size() != 0);
      end
      if (i == 450) idle_on = 1'b0;
      send_particle(rand_particle($urandom_range(0, 4) == 0), 1'b1);
    end

    drain();
    $display("covered %0d particle pushes over several time steps, %0d saturated",
             pushes_seen, ovf_seen);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
